// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files, included by dhkr_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/dhkr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dhkr_pkg;

  localparam int DEF_MAX_REGIONS = 4;
  localparam int DEF_QUEUE_DEPTH = 2;
  localparam int MAX_DIGITS      = 16;
  localparam int DIGIT_IDX_W     = 4;

  localparam logic [7:0]  DIGIT_BASE  = 8'd36;
  localparam logic [30:0] MIX_FACTOR  = 31'd1315423911;
  localparam logic [8:0]  CHAR_OFFSET = 9'd96;

  typedef enum logic [2:0] {
    REG_REGION_COUNT = 3'd0,
    REG_NODES0       = 3'd1,
    REG_NODES1       = 3'd2,
    REG_NODES2       = 3'd3,
    REG_NODES3       = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] key_char;
    logic       last;
  } dhkr_in_t;

  typedef struct packed {
    logic [63:0] hash_key;
    logic [1:0]  region_index;
    logic [7:0]  node_index;
  } dhkr_out_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
    logic [7:0]  remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_HASH,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_KEY,
    ST_REGION,
    ST_NODE,
    ST_DONE
  } back_state_t;

  // Byte read as a signed char, minus 96.
  function automatic logic signed [8:0] char_weight(input logic [7:0] b);
    return $signed({b[7], b}) - $signed(CHAR_OFFSET);
  endfunction

  function automatic logic [7:0] digit_glyph(input logic [5:0] d);
    return (d < 6'd10) ? (8'd48 + {2'b00, d}) : (8'd55 + {2'b00, d});
  endfunction

  // One hash term: weight times power, modulo 2^64. The weight is small.
  function automatic logic [63:0] weight_term(input logic [63:0] p,
                                              input logic signed [8:0] w);
    logic [8:0]  mag;
    logic [63:0] prod;
    mag  = w[8] ? (~w + 9'd1) : w;
    prod = p * mag[7:0];
    return w[8] ? (~prod + 64'd1) : prod;
  endfunction

  function automatic logic [63:0] times31(input logic [63:0] p);
    return {p[58:0], 5'b0} - p;
  endfunction

endpackage
`default_nettype wire

// ===== design/dhkr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dhkr_front
  import dhkr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire dhkr_in_t    item,
  output logic             push,
  output logic [63:0]      push_hash
);

  logic [63:0] running_hash, running_hash_next;
  logic [63:0] weight_power;

  assign running_hash_next = running_hash + weight_term(weight_power, char_weight(item.key_char));
  assign push      = accept && item.last;
  assign push_hash = running_hash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= 64'd0;
      weight_power <= 64'd1;
    end else if (accept) begin
      if (item.last) begin
        running_hash <= 64'd0;
        weight_power <= 64'd1;
      end else begin
        running_hash <= running_hash_next;
        weight_power <= times31(weight_power);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/dhkr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dhkr_queue
  import dhkr_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [63:0] wdata,
  input  wire logic        pop,
  output logic [63:0]      rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [63:0]   slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/dhkr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dhkr_div
  import dhkr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [63:0] work;
  logic [7:0]  rem;
  logic [7:0]  divisor;
  logic [2:0]  cnt;
  logic        busy;
  logic        done;
  logic [15:0] step;

  // Eight restoring steps: one dividend byte per cycle while busy, returns {quotient, remainder}.
  function automatic logic [15:0] byte_step(input logic [7:0] r, input logic [7:0] b,
                                            input logic [7:0] d);
    logic [8:0] t;
    logic [7:0] q;
    logic [7:0] rr;
    rr = r;
    q  = 8'd0;
    for (int i = 7; i >= 0; i--) begin
      t = {rr, b[i]};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        q[i] = 1'b1;
      end
      rr = t[7:0];
    end
    return {q, rr};
  endfunction

  assign step = byte_step(rem, work[63:56], divisor);

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = work;
  assign rsp.remainder = rem;

  always_ff @(posedge clk) begin
    if (req.start) begin
      work    <= req.dividend;
      rem     <= 8'd0;
      divisor <= req.divisor;
    end else if (busy) begin
      work <= {work[55:0], step[15:8]};
      rem  <= step[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/dhkr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dhkr_back
  import dhkr_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  wire logic [63:0] q_data,
  output logic             q_pop,
  input  wire logic [2:0]  region_count,
  input  wire logic [7:0]  node_counts [4],
  output logic             out_valid,
  input  wire logic        out_stall,
  output dhkr_out_t        out_data
);

  back_state_t state, state_next;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [63:0] h1, h2, pw, val, key;
  logic [62:0] prod_lo;
  logic [31:0] prod_hi;
  logic [5:0]  digits [MAX_DIGITS];
  logic [DIGIT_IDX_W-1:0] dcount, hidx;
  logic [1:0]  region;
  logic        div_run;
  logic        res_load;
  logic [2:0]  regions_eff;
  logic [7:0]  nodes_sel, nodes_eff;

  dhkr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (region_count == 3'd0) begin
      regions_eff = 3'd1;
    end else if (region_count > 3'(MAX_REGIONS)) begin
      regions_eff = 3'(MAX_REGIONS);
    end else begin
      regions_eff = region_count;
    end
  end

  assign nodes_sel = node_counts[region];
  assign nodes_eff = (nodes_sel == 8'd0) ? 8'd1 : nodes_sel;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!q_empty) state_next = ST_DIGIT;
      ST_DIGIT:  if (div_rsp.done && div_rsp.quotient == 64'd0) state_next = ST_HASH;
      ST_HASH:   if (hidx == '0) state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_KEY;
      ST_KEY:    state_next = ST_REGION;
      ST_REGION: if (div_rsp.done) state_next = ST_NODE;
      ST_NODE:   if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    res_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = val;
    div_req.divisor  = DIGIT_BASE;
    case (state)
      ST_IDLE:   q_pop = !q_empty;
      ST_DIGIT:  div_req.start = !div_run;
      ST_REGION: begin
        div_req.start    = !div_run;
        div_req.dividend = key;
        div_req.divisor  = {5'd0, regions_eff};
      end
      ST_NODE: begin
        div_req.start    = !div_run;
        div_req.dividend = key;
        div_req.divisor  = nodes_eff;
      end
      ST_DONE:   res_load = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
    end else if (div_req.start) begin
      div_run <= 1'b1;
    end else if (div_rsp.done) begin
      div_run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        h1     <= q_data;
        val    <= q_data;
        h2     <= 64'd0;
        pw     <= 64'd1;
        dcount <= '0;
      end
      ST_DIGIT: begin
        if (div_rsp.done) begin
          digits[dcount] <= div_rsp.remainder[5:0];
          dcount         <= dcount + DIGIT_IDX_W'(1);
          hidx           <= dcount;
          val            <= div_rsp.quotient;
        end
      end
      ST_HASH: begin
        // The most significant digit was found last, so it is weighted first.
        h2   <= h2 + weight_term(pw, char_weight(digit_glyph(digits[hidx])));
        pw   <= times31(pw);
        hidx <= hidx - DIGIT_IDX_W'(1);
      end
      ST_MUL_LO: prod_lo <= h2[31:0] * MIX_FACTOR;
      ST_MUL_HI: prod_hi <= 32'(h2[63:32] * MIX_FACTOR);
      ST_KEY:    key <= h1 + {1'b0, prod_lo} + {prod_hi, 32'd0};
      ST_REGION: if (div_rsp.done) region <= div_rsp.remainder[1:0];
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data.hash_key     <= key;
      out_data.region_index <= region;
      out_data.node_index   <= div_rsp.remainder;
    end
  end

  `ASSERT_NEVER(a_div_start_busy, div_req.start && div_rsp.busy, "divider restarted while busy")
  `ASSERT_PROP(a_pop_idle, q_pop |-> (state == ST_IDLE && !q_empty), "pop outside idle")
  `ASSERT_PROP(a_done_hold, (state == ST_DONE && !res_load) |=> state == ST_DONE, "result lost")
  `ASSERT_NEVER(a_digit_bound, dcount > DIGIT_IDX_W'(13), "too many base-36 digits")

endmodule
`default_nettype wire

// ===== design/double_hash_key_router_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Signals                        Moves
// input     in_valid, in_stall, in_data    one key byte and last flag per request
// output    out_valid, out_stall, out_data hash key, region and node index
// config    psel/penable/pwrite/paddr/...  five 32-bit registers at 4*i
//
// The front runs one multiply-accumulate per key byte that it takes.
// After the last byte the back divides the hash into base-36 digits (at most 13),
// hashes each digit, mixes in ST_MUL_LO/HI and ST_KEY, then runs two modulo divisions.
// A queue of QUEUE_DEPTH keys lets the front keep taking bytes meanwhile.
// in_stall rises only while that queue is full. Reset is synchronous, active high.
module double_hash_key_router_core
  import dhkr_pkg::*;
#(
  parameter int MAX_REGIONS = DEF_MAX_REGIONS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire dhkr_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output dhkr_out_t        out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0]  region_count;
  logic [7:0]  node_counts [4];
  logic        accept, push, pop, q_full, q_empty;
  logic [63:0] push_hash, q_data;
  reg_idx_t    idx;

  assign idx      = reg_idx_t'(paddr[4:2]);
  assign pready   = 1'b1;
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= 3'd1;
      for (int i = 0; i < 4; i++) node_counts[i] <= 8'd1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_REGION_COUNT: region_count   <= pwdata[2:0];
        REG_NODES0:       node_counts[0] <= pwdata[7:0];
        REG_NODES1:       node_counts[1] <= pwdata[7:0];
        REG_NODES2:       node_counts[2] <= pwdata[7:0];
        REG_NODES3:       node_counts[3] <= pwdata[7:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REGION_COUNT: prdata = {29'd0, region_count};
      REG_NODES0:       prdata = {24'd0, node_counts[0]};
      REG_NODES1:       prdata = {24'd0, node_counts[1]};
      REG_NODES2:       prdata = {24'd0, node_counts[2]};
      REG_NODES3:       prdata = {24'd0, node_counts[3]};
      default:          prdata = 32'd0;
    endcase
  end

  dhkr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .push      (push),
    .push_hash (push_hash)
  );

  dhkr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_hash),
    .pop   (pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  dhkr_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (pop),
    .region_count (region_count),
    .node_counts  (node_counts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import dhkr_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  dhkr_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  dhkr_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  double_hash_key_router_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state, kept apart from the block.
  logic [63:0] key_hash;
  logic [63:0] key_weight;
  logic [2:0]  regions_cfg;
  logic [7:0]  nodes_cfg [4];

  dhkr_in_t  byte_queue [$];
  dhkr_out_t route_queue [$];
  int        bytes_sent;
  int        errors;
  bit        driver_hold;

  function automatic logic [63:0] char_value(input logic [7:0] c);
    logic [63:0] v;
    v = {{56{c[7]}}, c};
    return v - 64'd96;
  endfunction

  function automatic logic [63:0] spelled_hash(input logic [63:0] v);
    logic [7:0]  digits [$];
    logic [63:0] h;
    logic [63:0] p;
    logic [5:0]  d;
    h = 64'd0;
    p = 64'd1;
    if (v == 0) digits.push_front(8'd48);
    while (v != 0) begin
      d = 6'(v % 36);
      digits.push_front(d < 6'd10 ? 8'd48 + {2'b00, d} : 8'd55 + {2'b00, d});
      v = v / 36;
    end
    foreach (digits[i]) begin
      h = h + char_value(digits[i]) * p;
      p = p * 31;
    end
    return h;
  endfunction

  task automatic predict_route(input dhkr_in_t req);
    dhkr_out_t   r;
    logic [63:0] k;
    logic [63:0] nreg;
    logic [63:0] nnode;
    key_hash = key_hash + char_value(req.key_char) * key_weight;
    key_weight = key_weight * 31;
    if (req.last) begin
      k = key_hash + spelled_hash(key_hash) * 64'd1315423911;
      nreg = (regions_cfg == 3'd0) ? 64'd1 :
             ((regions_cfg > 3'(DEF_MAX_REGIONS)) ? 64'(DEF_MAX_REGIONS) : 64'(regions_cfg));
      r.hash_key = k;
      r.region_index = 2'(k % nreg);
      nnode = (nodes_cfg[r.region_index] == 8'd0) ? 64'd1 : 64'(nodes_cfg[r.region_index]);
      r.node_index = 8'(k % nnode);
      route_queue = {route_queue, r};
      key_hash = 64'd0;
      key_weight = 64'd1;
    end
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver: one request per queue entry, random gap before each.
  int gap_left;
  int gap_draw;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      in_data <= '0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      predict_route(in_data);
      bytes_sent <= bytes_sent + 1;
      gap_draw = $urandom_range(0, 3);
      if (gap_draw == 0 && !driver_hold && byte_queue.size() > 0) begin
        in_data <= byte_queue.pop_front();
      end else begin
        in_valid <= 0;
      end
      gap_left <= (gap_draw > 0) ? gap_draw - 1 : 0;
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (!driver_hold && byte_queue.size() > 0) begin
        in_data <= byte_queue.pop_front();
        in_valid <= 1;
      end
    end
  end

  // Monitor with random stalls.
  int stall_left;
  int stall_draw;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (route_queue.size() == 0) begin
          $error("unexpected result hash_key %h", out_data.hash_key);
          errors++;
        end else begin
          dhkr_out_t e;
          e = route_queue.pop_front();
          if (e.hash_key !== out_data.hash_key) begin
            $error("hash_key expected %h actual %h", e.hash_key, out_data.hash_key);
            errors++;
          end
          if (e.region_index !== out_data.region_index) begin
            $error("region_index expected %0d actual %0d", e.region_index,
                   out_data.region_index);
            errors++;
          end
          if (e.node_index !== out_data.node_index) begin
            $error("node_index expected %0d actual %0d", e.node_index,
                   out_data.node_index);
            errors++;
          end
        end
        stall_draw = $urandom_range(0, 3);
        if (stall_draw > 0) begin
          stall_left <= stall_draw - 1;
          out_stall <= 1;
        end else begin
          stall_left <= 0;
          out_stall <= 0;
        end
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_REGION_COUNT) regions_cfg = v[2:0];
    else nodes_cfg[int'(idx) - 1] = v[7:0];
  endtask

  task automatic queue_key(input int len, input bit wild);
    dhkr_in_t b;
    for (int i = 0; i < len; i++) begin
      b.key_char = wild ? 8'($urandom) : 8'($urandom_range(32, 126));
      b.last = (i == len - 1);
      byte_queue = {byte_queue, b};
    end
  endtask

  task automatic drain;
    while (byte_queue.size() > 0 || in_valid || route_queue.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int total;
    dhkr_in_t b;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    errors = 0;
    bytes_sent = 0;
    driver_hold = 0;
    key_hash = 0;
    key_weight = 1;
    regions_cfg = 1;
    for (int i = 0; i < 4; i++) nodes_cfg[i] = 1;
    repeat (12) @(posedge clk);
    rst <= 0;
    driver_hold = 1;

    // Directed: byte extremes, a zero-valued first hash, single-byte keys, a 14-byte key.
    b.key_char = 8'h60; b.last = 1; byte_queue = {byte_queue, b};
    b.key_char = 8'h00; b.last = 1; byte_queue = {byte_queue, b};
    b.key_char = 8'hFF; b.last = 0; byte_queue = {byte_queue, b};
    b.key_char = 8'h80; b.last = 0; byte_queue = {byte_queue, b};
    b.key_char = 8'h7F; b.last = 1; byte_queue = {byte_queue, b};
    b.key_char = 8'h55; b.last = 0; byte_queue = {byte_queue, b};
    b.key_char = 8'hAA; b.last = 1; byte_queue = {byte_queue, b};
    queue_key(14, 0);
    driver_hold = 0;
    drain();

    // Several register settings, extremes and out-of-range counts included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          apb_write(REG_REGION_COUNT, 4);
          apb_write(REG_NODES0, 255); apb_write(REG_NODES1, 1);
          apb_write(REG_NODES2, 128); apb_write(REG_NODES3, 7);
        end
        1: begin
          apb_write(REG_REGION_COUNT, 0);
          apb_write(REG_NODES0, 0);
        end
        2: begin
          apb_write(REG_REGION_COUNT, 7);
          apb_write(REG_NODES3, 0); apb_write(REG_NODES2, 255);
        end
        3: begin
          apb_write(REG_REGION_COUNT, 5);
          apb_write(REG_NODES0, 1); apb_write(REG_NODES1, 254);
        end
        default: begin
          apb_write(REG_REGION_COUNT, $urandom_range(0, 7));
          apb_write(REG_NODES0, $urandom_range(0, 255));
          apb_write(REG_NODES1, $urandom_range(0, 255));
          apb_write(REG_NODES2, $urandom_range(0, 255));
          apb_write(REG_NODES3, $urandom_range(0, 255));
        end
      endcase
      total = 0;
      while (total < 90) begin
        int len;
        len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 30) : $urandom_range(1, 12);
        queue_key(len, $urandom_range(0, 3) == 0);
        total += len;
      end
      // Halfway: the sender waits until all results have come back.
      if (phase == 2) begin
        drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("double_hash_key_router_core verification clean");
    end else begin
      $display("double_hash_key_router_core verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("double_hash_key_router_core verification failed");
    $finish;
  end

endmodule
